[hw/rtl/wtcm_pkg.sv]
// ----------------------------------------------------------------------------
// wtcm_pkg
// Shared types, constants and helpers of the wall texture column mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package wtcm_pkg;

  // largest texture side, texture register width
  localparam int unsigned TEX_MAX   = 256;
  localparam int unsigned TEX_REG_W = 9;
  localparam int unsigned SH_W      = 11;

  // field widths
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LH_W    = 16;
  localparam int unsigned TID_W   = 3;
  localparam int unsigned TEXEL_W = 8;

  // row stepping arithmetic
  localparam int unsigned QUO_W  = TEX_REG_W + FRAC_W;   // texture height << 16
  localparam int unsigned NUM_W  = LH_W + 2;
  localparam int unsigned PROD_W = NUM_W + QUO_W + 1;
  localparam int unsigned POS_W  = 40;
  localparam int unsigned TYI_W  = POS_W - FRAC_W;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SH_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd2;

  // item opcodes
  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  // texture ids
  localparam logic [TID_W-1:0] TEX_NORTH = 3'd0;
  localparam logic [TID_W-1:0] TEX_SOUTH = 3'd1;
  localparam logic [TID_W-1:0] TEX_WEST  = 3'd2;
  localparam logic [TID_W-1:0] TEX_EAST  = 3'd3;
  localparam logic [TID_W-1:0] TEX_DOOR  = 3'd4;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic pos_wr;
    logic row_go;
  } wtcm_cmd_t;

  typedef struct packed {
    logic active;
    logic out_blocked;
  } wtcm_sts_t;

  // texture side with zero and oversize values saturated
  function automatic logic [TEX_REG_W-1:0] eff_size(input logic [TEX_REG_W-1:0] v);
    logic [TEX_REG_W-1:0] r;
    if (v == '0) begin
      r = TEX_REG_W'(1);
    end else if (v > TEX_REG_W'(TEX_MAX)) begin
      r = TEX_REG_W'(TEX_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/wtcm_ctrl.sv]
// ----------------------------------------------------------------------------
// wtcm_ctrl
// Sequencer: input handshake, column setup steps and row item issue.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcm_ctrl import wtcm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      in_opcode,
  input  wire wtcm_sts_t sts,
  output wtcm_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_POS
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               accept;

  assign in_stall = (state_r != ST_IDLE) || sts.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load     = accept && (in_opcode == OP_SETUP);
    cmd.row_go   = accept && (in_opcode == OP_ROW) && sts.active;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        cmd.pos_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wtcm_dpath.sv]
// ----------------------------------------------------------------------------
// wtcm_dpath
// Column state, texel column, row step divider, start position and row output.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcm_dpath import wtcm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire wtcm_cmd_t             cmd,
  output wtcm_sts_t                  sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [COL_W-1:0]      in_column,
  input  wire logic                  in_is_door,
  input  wire logic                  in_side,
  input  wire logic                  in_step_x_negative,
  input  wire logic                  in_step_y_negative,
  input  wire logic                  in_ray_dir_x_positive,
  input  wire logic                  in_ray_dir_y_negative,
  input  wire logic [FRAC_W-1:0]     in_wall_hit_fraction,
  input  wire logic [LH_W-1:0]       in_line_height,
  input  wire logic [ROW_W-1:0]      in_draw_start,
  input  wire logic [ROW_W-1:0]      in_draw_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COL_W-1:0]           out_column,
  output logic [ROW_W-1:0]           out_row,
  output logic [TID_W-1:0]           out_texture_id,
  output logic [TEXEL_W-1:0]         out_texel_x,
  output logic [TEXEL_W-1:0]         out_texel_y,
  output logic                       out_darken,
  output logic                       out_last
);

  // configuration
  logic [SH_W-1:0]      screen_height_r;
  logic [TEX_REG_W-1:0] tex_width_r;
  logic [TEX_REG_W-1:0] tex_height_r;

  // column state
  logic                 active_r, active_nxt;
  logic [COL_W-1:0]     cur_column_r;
  logic [ROW_W-1:0]     cur_row_r;
  logic [ROW_W-1:0]     end_row_r;
  logic [TID_W-1:0]     tex_sel_r;
  logic [TEXEL_W-1:0]   tex_col_r;
  logic                 dim_flag_r;
  logic [POS_W-1:0]     row_pos_r;

  // divider and start position
  logic [LH_W-1:0]          lh_r;
  logic [QUO_W-1:0]         dvd_r;
  logic [LH_W-1:0]          rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                     out_valid_r, out_valid_nxt;

  // setup logic
  logic [TEX_REG_W-1:0]        w_eff, h_set, h_row;
  logic [QUO_W-1:0]            tx_prod;
  logic [TEX_REG_W-1:0]        tx_raw, tx_clamp, tx_fin;
  logic                        mirror;
  logic [TID_W-1:0]            sel_nxt;
  logic [LH_W-1:0]             lh_in;
  logic signed [NUM_W-1:0]     num_nxt;
  logic [LH_W:0]               trial;
  logic                        ge;
  logic [LH_W:0]               trial_sub;

  // row logic
  logic [TYI_W-1:0]            ty_raw, ty_fin;
  logic                        last_nxt;

  assign w_eff = eff_size(tex_width_r);
  assign h_set = eff_size(tex_height_r);
  assign h_row = h_set;

  always_comb begin
    tx_prod  = QUO_W'(in_wall_hit_fraction) * QUO_W'(w_eff);
    tx_raw   = tx_prod[QUO_W-1:FRAC_W];
    tx_clamp = (tx_raw >= w_eff) ? (w_eff - TEX_REG_W'(1)) : tx_raw;
    mirror   = (!in_side && in_ray_dir_x_positive) || (in_side && in_ray_dir_y_negative);
    tx_fin   = mirror ? (w_eff - TEX_REG_W'(1) - tx_clamp) : tx_clamp;
  end

  always_comb begin
    if (in_is_door) begin
      sel_nxt = TEX_DOOR;
    end else if (!in_side) begin
      sel_nxt = in_step_x_negative ? TEX_WEST : TEX_EAST;
    end else begin
      sel_nxt = in_step_y_negative ? TEX_NORTH : TEX_SOUTH;
    end
  end

  assign lh_in   = (in_line_height == '0) ? LH_W'(1) : in_line_height;
  assign num_nxt = $signed(NUM_W'({in_draw_start, 1'b0})) - $signed(NUM_W'(screen_height_r))
                 + $signed(NUM_W'(lh_in));

  // restoring divide, one quotient bit per step
  assign trial     = {rem_r, dvd_r[QUO_W-1]};
  assign ge        = trial >= {1'b0, lh_r};
  assign trial_sub = trial - {1'b0, lh_r};

  // texel row of the current screen row
  always_comb begin
    ty_raw   = row_pos_r[POS_W-1] ? '0 : row_pos_r[POS_W-1:FRAC_W];
    ty_fin   = (ty_raw >= TYI_W'(h_row)) ? TYI_W'(h_row - TEX_REG_W'(1)) : ty_raw;
    last_nxt = (cur_row_r == end_row_r);
  end

  always_comb begin
    active_nxt = active_r;
    if (cmd.load) begin
      active_nxt = (in_draw_start <= in_draw_end);
    end else if (cmd.row_go && last_nxt) begin
      active_nxt = 1'b0;
    end
    out_valid_nxt = cmd.row_go || (out_valid_r && out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= SH_W'(480);
      tex_width_r     <= TEX_REG_W'(64);
      tex_height_r    <= TEX_REG_W'(64);
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
          CFG_TEX_WIDTH:     tex_width_r     <= cfg_wdata[TEX_REG_W-1:0];
          CFG_TEX_HEIGHT:    tex_height_r    <= cfg_wdata[TEX_REG_W-1:0];
          default: ;
        endcase
      end
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_column_r <= in_column;
      cur_row_r    <= in_draw_start;
      end_row_r    <= in_draw_end;
      tex_sel_r    <= sel_nxt;
      tex_col_r    <= tx_fin[TEXEL_W-1:0];
      dim_flag_r   <= in_side;
      lh_r         <= lh_in;
      num_r        <= num_nxt;
      dvd_r        <= {h_set, FRAC_W'(0)};
      rem_r        <= '0;
      quo_r        <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[LH_W-1:0] : trial[LH_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dvd_r <= {dvd_r[QUO_W-2:0], 1'b0};
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(num_r) * $signed({1'b0, quo_r});
    end
    if (cmd.pos_wr) begin
      row_pos_r <= prod_r[POS_W:1];
    end else if (cmd.row_go) begin
      row_pos_r <= row_pos_r + POS_W'(quo_r);
      cur_row_r <= cur_row_r + ROW_W'(1);
    end
    if (cmd.row_go) begin
      out_column     <= cur_column_r;
      out_row        <= cur_row_r;
      out_texture_id <= tex_sel_r;
      out_texel_x    <= tex_col_r;
      out_texel_y    <= ty_fin[TEXEL_W-1:0];
      out_darken     <= dim_flag_r;
      out_last       <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign sts.active      = active_r;
  assign sts.out_blocked = out_valid_r && out_stall;

endmodule

`default_nettype wire

[hw/rtl/wall_texture_column_mapper_unit.sv]
// ----------------------------------------------------------------------------
// wall_texture_column_mapper_unit
// Maps a raycaster wall slice to texture id, texel column and per-row texel row.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): a setup item (opcode 0) starts a
//   screen column, a row item (opcode 1) asks for the next pixel of it
//   result channel (out_valid / out_stall): one item per row item while a
//   column is active; setup items and rows with no active column give none
//   setup: once accepted, in_stall stays high while the one-bit-per-cycle
//   row step divider runs, then for one multiply and one start position
//   write
//   row items: one per cycle when not stalled, the result sits in the
//   output register the cycle after acceptance; a new row item is taken
//   while that result is being taken in the same cycle
//   receiver stall: a held result stalls the input side until it is taken
//   configuration: cfg_we/cfg_index/cfg_wdata, user writes when idle, unenforced
//   reset: synchronous on rst_n low; no column active, output empty,
//   screen height 480, texture size 64 by 64
// ----------------------------------------------------------------------------
`default_nettype none

module wall_texture_column_mapper_unit import wtcm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [COL_W-1:0]      in_column,
  input  wire logic                  in_is_door,
  input  wire logic                  in_side,
  input  wire logic                  in_step_x_negative,
  input  wire logic                  in_step_y_negative,
  input  wire logic                  in_ray_dir_x_positive,
  input  wire logic                  in_ray_dir_y_negative,
  input  wire logic [FRAC_W-1:0]     in_wall_hit_fraction,
  input  wire logic [LH_W-1:0]       in_line_height,
  input  wire logic [ROW_W-1:0]      in_draw_start,
  input  wire logic [ROW_W-1:0]      in_draw_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COL_W-1:0]           out_column,
  output logic [ROW_W-1:0]           out_row,
  output logic [TID_W-1:0]           out_texture_id,
  output logic [TEXEL_W-1:0]         out_texel_x,
  output logic [TEXEL_W-1:0]         out_texel_y,
  output logic                       out_darken,
  output logic                       out_last
);

  wtcm_cmd_t cmd;
  wtcm_sts_t sts;

  wtcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  wtcm_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_column             (in_column),
    .in_is_door            (in_is_door),
    .in_side               (in_side),
    .in_step_x_negative    (in_step_x_negative),
    .in_step_y_negative    (in_step_y_negative),
    .in_ray_dir_x_positive (in_ray_dir_x_positive),
    .in_ray_dir_y_negative (in_ray_dir_y_negative),
    .in_wall_hit_fraction  (in_wall_hit_fraction),
    .in_line_height        (in_line_height),
    .in_draw_start         (in_draw_start),
    .in_draw_end           (in_draw_end),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_column            (out_column),
    .out_row               (out_row),
    .out_texture_id        (out_texture_id),
    .out_texel_x           (out_texel_x),
    .out_texel_y           (out_texel_y),
    .out_darken            (out_darken),
    .out_last              (out_last)
  );

endmodule

`default_nettype wire
